// ----- src/rddr_pkg.sv -----
// ----------------------------------------------------------------------------
// rddr_pkg: shared types for the radar dirty-delta report table
// Beat payloads, function codes, sequencer states and the bitmap command.
// ----------------------------------------------------------------------------
`default_nettype none

package rddr_pkg;

  localparam int ANGLES_DEF  = 128;
  localparam int MAX_RUN_DEF = 28;
  localparam int ANGLE_W     = 8;
  localparam int VALUE_W     = 8;
  // Cursor width: holds any angle plus one past the last.
  localparam int CUR_W       = 9;
  // Bitmap word width examined per scan cycle.
  localparam int SCAN_W      = 16;
  localparam int SCAN_PW     = $clog2(SCAN_W);

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_ACK      = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [ANGLE_W-1:0] angle;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               empty_res;
    logic [ANGLE_W-1:0] angle_res;
    logic [VALUE_W-1:0] value_res;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic               wr;
    logic [ANGLE_W-1:0] wr_angle;
    logic               clr_flight;
    logic               ack;
    logic               mark;
    logic [CUR_W-1:0]   mark_angle;
  } map_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [CUR_W-1:0] pos;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- src/radar_dirty_delta_report_table_unit.sv -----
// ----------------------------------------------------------------------------
// radar_dirty_delta_report_table_unit: per-angle store with delta reports
// Stores one byte per angle and reports runs of changed angles on request.
//
// Input channel (in_valid / in_stall / in_data): one beat per command.
// Writes and acknowledges complete in the accepting cycle and give no output.
// A dispatch holds the input stalled while the sequencer scans the dirty map
// one 16-bit word per cycle, reads the first value from the value RAM, then
// emits one output beat per cycle while the receiver does not stall, for each
// angle of the run, up to MAX_RUN beats. A dispatch with nothing dirty gives
// a single beat with empty_res and last set.
//
// The output beat sits in a register; while the receiver stalls, the run
// pauses and the beat holds. New commands are taken while the last beat of a
// run still waits. Reset clears all flag maps and the sequencer; the value
// RAM is not cleared, since only written angles are ever reported.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_dirty_delta_report_table_unit
  import rddr_pkg::*;
#(
  parameter int ANGLES  = ANGLES_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int NW  = (ANGLES + SCAN_W - 1) / SCAN_W;
  localparam int WIW = $clog2(NW);
  localparam int RAW = $clog2(ANGLES);
  localparam int NRW = $clog2(MAX_RUN + 1);

  state_t             state, state_next;
  logic [WIW-1:0]     wi, wi_next;
  logic [CUR_W-1:0]   cur, cur_next;
  logic [NRW-1:0]     n, n_next;
  logic               ov, ov_next;
  out_t               od, od_next;

  map_cmd_t           cmd;
  scan_res_t          scan;
  logic [CUR_W-1:0]   probe_angle;
  logic               probe_dirty;

  logic               ram_we;
  logic               ram_re;
  logic [RAW-1:0]     ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               slot_free;
  logic [NRW-1:0]     n_inc;
  logic               run_end;

  rddr_maps #(
    .ANGLES(ANGLES)
  ) u_maps (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .scan_idx   (wi),
    .scan       (scan),
    .probe_angle(probe_angle),
    .probe_dirty(probe_dirty)
  );

  rddr_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(ANGLES)
  ) u_values (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_data.angle[RAW-1:0]),
    .wdata(in_data.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign slot_free   = !ov || !out_stall;
  assign probe_angle = cur + CUR_W'(1);
  assign n_inc       = n + NRW'(1);
  // The run stops at the run limit, at the top angle, or at a clean angle.
  assign run_end     = (n_inc == NRW'(MAX_RUN)) || !probe_dirty;

  always_comb begin
    state_next = state;
    wi_next    = wi;
    cur_next   = cur;
    n_next     = n;
    ov_next    = ov && out_stall;
    od_next    = od;
    cmd        = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = cur[RAW-1:0];
    in_stall   = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_WRITE: begin
              cmd.wr       = 1'b1;
              cmd.wr_angle = in_data.angle;
              ram_we       = CUR_W'(in_data.angle) < CUR_W'(ANGLES);
            end
            FUNC_DISPATCH: begin
              cmd.clr_flight = 1'b1;
              wi_next        = '0;
              state_next     = ST_SCAN;
            end
            FUNC_ACK: begin
              cmd.ack = 1'b1;
            end
            FUNC_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan.hit) begin
          cur_next   = scan.pos;
          n_next     = '0;
          state_next = ST_READ;
        end else if (wi == WIW'(NW - 1)) begin
          state_next = ST_EMPTY;
        end else begin
          wi_next = wi + WIW'(1);
        end
      end

      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_LOAD;
      end

      ST_LOAD: begin
        if (slot_free) begin
          ov_next           = 1'b1;
          od_next.empty_res = 1'b0;
          od_next.angle_res = cur[ANGLE_W-1:0];
          od_next.value_res = ram_rdata;
          od_next.last      = run_end;
          cmd.mark          = 1'b1;
          cmd.mark_angle    = cur;
          if (run_end) begin
            state_next = ST_IDLE;
          end else begin
            // Fetch the next value while this beat goes out.
            cur_next  = probe_angle;
            n_next    = n_inc;
            ram_re    = 1'b1;
            ram_raddr = probe_angle[RAW-1:0];
          end
        end
      end

      ST_EMPTY: begin
        if (slot_free) begin
          ov_next           = 1'b1;
          od_next.empty_res = 1'b1;
          od_next.angle_res = '0;
          od_next.value_res = '0;
          od_next.last      = 1'b1;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    wi  <= wi_next;
    cur <= cur_next;
    n   <= n_next;
    od  <= od_next;
  end

  assign out_valid = ov;
  assign out_data  = od;

endmodule

`default_nettype wire

// ----- src/rddr_ram.sv -----
// ----------------------------------------------------------------------------
// rddr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rddr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rddr_maps.sv -----
// ----------------------------------------------------------------------------
// rddr_maps: dirty, in-flight and changed-while-sending bitmaps
// Holds the three per-angle flag maps, applies update commands, and provides
// a one-word-per-cycle first-dirty scan and a single-bit dirty probe.
// ----------------------------------------------------------------------------
`default_nettype none

module rddr_maps
  import rddr_pkg::*;
#(
  parameter int ANGLES = ANGLES_DEF,
  localparam int NW  = (ANGLES + SCAN_W - 1) / SCAN_W,
  localparam int NB  = NW * SCAN_W,
  localparam int IW  = $clog2(NB),
  localparam int WIW = $clog2(NW)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire map_cmd_t         cmd,
  input  wire logic [WIW-1:0]   scan_idx,
  output scan_res_t             scan,
  input  wire logic [CUR_W-1:0] probe_angle,
  output logic                  probe_dirty
);

  // Bits at or above ANGLES pad the last word and are never set.
  logic [NB-1:0] dirty, dirty_next;
  logic [NB-1:0] flight, flight_next;
  logic [NB-1:0] changed, changed_next;

  logic [CUR_W-1:0]  wr_ext;
  logic              wr_ok;
  logic [IW-1:0]     wr_idx;
  logic [SCAN_W-1:0] word;
  logic [SCAN_PW-1:0] first;

  assign wr_ext = CUR_W'(cmd.wr_angle);
  assign wr_ok  = cmd.wr && (wr_ext < CUR_W'(ANGLES));
  assign wr_idx = wr_ext[IW-1:0];

  always_comb begin
    dirty_next   = dirty;
    flight_next  = flight;
    changed_next = changed;
    if (wr_ok) begin
      dirty_next[wr_idx] = 1'b1;
      if (flight[wr_idx]) begin
        changed_next[wr_idx] = 1'b1;
      end
    end
    if (cmd.ack) begin
      dirty_next   = (dirty & ~flight) | changed;
      changed_next = '0;
    end
    if (cmd.clr_flight) begin
      flight_next = '0;
    end
    if (cmd.mark) begin
      flight_next[cmd.mark_angle[IW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty   <= '0;
      flight  <= '0;
      changed <= '0;
    end else begin
      dirty   <= dirty_next;
      flight  <= flight_next;
      changed <= changed_next;
    end
  end

  // Word scan: lowest set bit of the selected word.
  assign word = dirty[scan_idx*SCAN_W +: SCAN_W];

  always_comb begin
    first = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        first = SCAN_PW'(i);
      end
    end
    scan.hit = |word;
    scan.pos = CUR_W'({scan_idx, first});
  end

  assign probe_dirty = (probe_angle < CUR_W'(ANGLES)) ? dirty[probe_angle[IW-1:0]] : 1'b0;

endmodule

`default_nettype wire
